// ===== design/cartridge_rom_sram_mapper_assert.svh =====
// ----------------------------------------------------------------------------
// Cartridge mapper assertion macros
// Shared concurrent assertion forms for the mapper checker.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_ROM_SRAM_MAPPER_ASSERT_SVH
`define CARTRIDGE_ROM_SRAM_MAPPER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRSM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("mapper assertion failed");

// The condition must never be seen at a clock edge.
`define CRSM_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("mapper assertion failed");

`endif

// ===== design/crsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Cartridge mapper package
// Types, constants and register indexes shared by the mapper modules.
// ----------------------------------------------------------------------------
package crsm_pkg;

	localparam int unsigned RamBytesDefault = 131072;
	localparam int unsigned OffW = 17;
	localparam int unsigned RomW = 23;
	localparam int unsigned QDepth = 4;

	localparam logic [7:0] REG_HIROM_MODE = 8'd0;
	localparam logic [7:0] REG_ROM_BANK_MASK = 8'd1;
	localparam logic [7:0] REG_SRAM_PRESENT = 8'd2;
	localparam logic [7:0] REG_SRAM_OFFSET_MASK = 8'd3;

	localparam logic [7:0] LO_RAM_BANK_FIRST = 8'h70;
	localparam logic [7:0] LO_RAM_BANK_END = 8'h7E;
	localparam logic [15:0] LO_ADDR_MASK = 16'h7FFF;
	localparam logic [15:0] HI_RAM_ADDR_FIRST = 16'h6000;
	localparam logic [15:0] ROM_AREA_START = 16'h8000;
	localparam logic [7:0] HI_BANK_MASK = 8'h3F;
	localparam logic [15:0] HI_ADDR_MASK = 16'h1FFF;
	localparam logic [7:0] HI_BANK_LIMIT = 8'h40;
	localparam logic [7:0] HI_BANK_MIRROR = 8'h80;
	localparam logic [7:0] HI_BANK_END = 8'hC0;

	typedef enum logic [1:0] {
		OUT_RAM_READ      = 2'd0,
		OUT_ROM_FETCH     = 2'd1,
		OUT_RAM_WRITTEN   = 2'd2,
		OUT_WRITE_IGNORED = 2'd3
	} outcome_t;

	typedef struct packed {
		logic             hirom_mode;
		logic [7:0]       rom_bank_mask;
		logic             sram_present;
		logic [OffW-1:0]  sram_offset_mask;
	} cfg_t;

	// Decoded access inside the front pipeline; raw is the masked RAM offset.
	typedef struct packed {
		logic             kind;
		logic             hit;
		logic [OffW-1:0]  raw;
		logic [7:0]       data;
		logic [RomW-1:0]  rom;
	} cls_t;

	// Classified access waiting for the back end; off is the final RAM offset.
	typedef struct packed {
		logic             kind;
		logic             hit;
		logic [OffW-1:0]  off;
		logic [7:0]       data;
		logic [RomW-1:0]  rom;
	} q_entry_t;

endpackage

// ===== design/crsm_front.sv =====
// ----------------------------------------------------------------------------
// Cartridge mapper front end
// Decodes each access, then reduces the RAM offset modulo the store size.
// ----------------------------------------------------------------------------
module crsm_front #(
	parameter int unsigned RAM_BYTES = crsm_pkg::RamBytesDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  crsm_pkg::cfg_t      cfg,
	input  logic                accept,
	input  logic                kind,
	input  logic [7:0]          bank,
	input  logic [15:0]         address,
	input  logic [7:0]          write_data,
	output logic                push,
	output crsm_pkg::q_entry_t  push_entry,
	output logic [1:0]          inflight
);
	import crsm_pkg::*;

	localparam logic [20:0] Div = 21'(RAM_BYTES);
	localparam logic [24:0] Recip = 25'((64'd1 << 34) / RAM_BYTES);

	cls_t        cls;
	cls_t        cls_s1, cls_s2, cls_s3;
	logic        v_s1, v_s2, v_s3;
	logic [41:0] prod_s2;
	logic [28:0] qd_s3;
	logic [28:0] diff;
	logic [OffW-1:0] rem;
	logic [7:0]  lo_bank;
	logic [7:0]  hi_bank;
	logic [7:0]  hi_rbank;
	logic [15:0] lo_addr;
	logic [15:0] hi_addr;
	logic        lo_hit, hi_hit;
	logic [OffW-1:0] lo_raw, hi_raw;
	logic [RomW-1:0] lo_rom, hi_rom;

	always_comb begin
		lo_bank  = bank - LO_RAM_BANK_FIRST;
		hi_bank  = bank & HI_BANK_MASK;
		hi_rbank = bank & HI_BANK_MASK & cfg.rom_bank_mask;
		lo_addr  = address & LO_ADDR_MASK;
		hi_addr  = address & HI_ADDR_MASK;
		lo_hit = cfg.sram_present && (address < ROM_AREA_START)
			&& (bank >= LO_RAM_BANK_FIRST) && (bank < LO_RAM_BANK_END);
		hi_hit = cfg.sram_present && (address >= HI_RAM_ADDR_FIRST)
			&& (address < ROM_AREA_START)
			&& ((bank < HI_BANK_LIMIT) || ((bank >= HI_BANK_MIRROR) && (bank < HI_BANK_END)));
		lo_raw = {lo_bank[1:0], lo_addr[14:0]};
		hi_raw = {hi_bank[3:0], hi_addr[12:0]};
		lo_rom = {bank & cfg.rom_bank_mask, lo_addr[14:0]};
		hi_rom = {1'b0, hi_rbank[5:0], address};
		cls.kind = kind;
		cls.data = write_data;
		if (cfg.hirom_mode) begin
			cls.hit = hi_hit;
			cls.raw = hi_raw & cfg.sram_offset_mask;
			cls.rom = hi_rom;
		end else begin
			cls.hit = lo_hit;
			cls.raw = lo_raw & cfg.sram_offset_mask;
			cls.rom = lo_rom;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		cls_s1  <= cls;
		cls_s2  <= cls_s1;
		prod_s2 <= 42'(cls_s1.raw) * 42'(Recip);
		cls_s3  <= cls_s2;
		qd_s3   <= 29'(prod_s2[41:34]) * 29'(Div);
	end

	// The reciprocal estimate of the quotient is low by at most one.
	always_comb begin
		diff = 29'(cls_s3.raw) - qd_s3;
		rem  = diff[OffW-1:0];
		push_entry.kind = cls_s3.kind;
		push_entry.hit  = cls_s3.hit;
		push_entry.data = cls_s3.data;
		push_entry.rom  = cls_s3.rom;
		if (21'(rem) >= Div) begin
			push_entry.off = rem - Div[OffW-1:0];
		end else begin
			push_entry.off = rem;
		end
	end

	assign push     = v_s3;
	assign inflight = 2'(v_s1) + 2'(v_s2) + 2'(v_s3);

endmodule

// ===== design/crsm_queue.sv =====
// ----------------------------------------------------------------------------
// Cartridge mapper access queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module crsm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  crsm_pkg::q_entry_t  push_entry,
	input  logic                pop,
	output logic                not_empty,
	output crsm_pkg::q_entry_t  head,
	output logic [2:0]          count
);
	import crsm_pkg::*;

	q_entry_t   slots [QDepth];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + 3'(push) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_entry;
		end
	end

	assign not_empty = (count_q != 3'd0);
	assign head      = slots[rd_ptr_q];
	assign count     = count_q;

endmodule

// ===== design/crsm_back.sv =====
// ----------------------------------------------------------------------------
// Cartridge mapper back end
// Owns the battery RAM, clears it after reset and forms each result.
// ----------------------------------------------------------------------------
module crsm_back #(
	parameter int unsigned RAM_BYTES = crsm_pkg::RamBytesDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  crsm_pkg::q_entry_t  entry,
	output logic                take,
	output logic                clearing,
	output logic                done,
	output logic [1:0]          outcome,
	output logic [7:0]          read_data,
	output logic [22:0]         rom_address
);
	import crsm_pkg::*;

	localparam int unsigned AddrW = $clog2(RAM_BYTES);

	logic [7:0]        mem [RAM_BYTES];
	logic [7:0]        rd_q;
	logic [AddrW-1:0]  idx;
	logic [AddrW-1:0]  clr_addr_q;
	logic              clr_q;
	logic              done_q;
	logic              rdsel_q;
	outcome_t          outcome_q;
	outcome_t          outcome_d;
	logic [RomW-1:0]   rom_q;

	assign idx  = AddrW'(entry.off);
	assign take = q_valid && !clr_q;

	always_comb begin
		unique case ({entry.kind, entry.hit})
			2'b01:   outcome_d = OUT_RAM_READ;
			2'b00:   outcome_d = OUT_ROM_FETCH;
			2'b11:   outcome_d = OUT_RAM_WRITTEN;
			default: outcome_d = OUT_WRITE_IGNORED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			done_q     <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + AddrW'(1);
				if (clr_addr_q == AddrW'(RAM_BYTES - 1)) begin
					clr_q <= 1'b0;
				end
			end
			done_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (take && entry.hit && entry.kind) begin
			mem[idx] <= entry.data;
		end
		if (take) begin
			rd_q <= mem[idx];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			outcome_q <= outcome_d;
			rdsel_q   <= (outcome_d == OUT_RAM_READ);
			rom_q     <= (outcome_d == OUT_ROM_FETCH) ? entry.rom : '0;
		end
	end

	assign clearing    = clr_q;
	assign done        = done_q;
	assign outcome     = outcome_q;
	assign read_data   = rdsel_q ? rd_q : 8'd0;
	assign rom_address = rom_q;

endmodule

// ===== design/cartridge_rom_sram_mapper.sv =====
// ----------------------------------------------------------------------------
// Cartridge ROM and battery RAM mapper
// Decodes bus accesses under low-ROM or high-ROM mapping into RAM reads,
// RAM writes, ROM fetch addresses or ignored writes.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// access    in         start, busy          kind, bank, address, write_data
// result    out        done (one cycle)     outcome, read_data, rom_address
// config    in         cfg_valid, cfg_ready cfg_index, cfg_data
//
// Accesses are not taken back to back without a break: busy rises once
// the three pipeline stages and the queue together hold four accesses.
// The result strobe follows the three-stage decode and modulo pipeline,
// the queue and the registered RAM read.
// After reset the battery RAM is cleared one byte a cycle, with busy high.
// The configuration port is always ready.
// ----------------------------------------------------------------------------
module cartridge_rom_sram_mapper #(
	parameter int unsigned RAM_BYTES = crsm_pkg::RamBytesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [7:0]  bank,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	output logic        done,
	output logic [1:0]  outcome,
	output logic [7:0]  read_data,
	output logic [22:0] rom_address,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	import crsm_pkg::*;

	cfg_t       cfg_q;
	logic       accept;
	logic       push;
	q_entry_t   push_entry;
	logic [1:0] inflight;
	logic       q_valid;
	q_entry_t   head;
	logic [2:0] count;
	logic       take;
	logic       clearing;
	logic [3:0] occupancy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HIROM_MODE:       cfg_q.hirom_mode       <= cfg_data[0];
				REG_ROM_BANK_MASK:    cfg_q.rom_bank_mask    <= cfg_data[7:0];
				REG_SRAM_PRESENT:     cfg_q.sram_present     <= cfg_data[0];
				REG_SRAM_OFFSET_MASK: cfg_q.sram_offset_mask <= cfg_data;
				default: ;
			endcase
		end
	end

	assign occupancy = 4'(count) + 4'(inflight);
	assign busy      = clearing || (occupancy >= 4'(QDepth));
	assign accept    = start && !busy;

	crsm_front #(.RAM_BYTES(RAM_BYTES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (accept),
		.kind       (kind),
		.bank       (bank),
		.address    (address),
		.write_data (write_data),
		.push       (push),
		.push_entry (push_entry),
		.inflight   (inflight)
	);

	crsm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (take),
		.not_empty  (q_valid),
		.head       (head),
		.count      (count)
	);

	crsm_back #(.RAM_BYTES(RAM_BYTES)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.entry       (head),
		.take        (take),
		.clearing    (clearing),
		.done        (done),
		.outcome     (outcome),
		.read_data   (read_data),
		.rom_address (rom_address)
	);

endmodule

// ===== design/crsm_checker.sv =====
// ----------------------------------------------------------------------------
// Cartridge mapper port checker
// Watches the mapper ports and flags inconsistent results.
// ----------------------------------------------------------------------------
`include "cartridge_rom_sram_mapper_assert.svh"

module crsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        kind,
	input logic [7:0]  bank,
	input logic [15:0] address,
	input logic [7:0]  write_data,
	input logic        done,
	input logic [1:0]  outcome,
	input logic [7:0]  read_data,
	input logic [22:0] rom_address,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [7:0]  cfg_index,
	input logic [16:0] cfg_data
);
	import crsm_pkg::*;

	`CRSM_ASSERT_IMP(a_rdata_only_on_read, clk, arst_n,
		done && (outcome != OUT_RAM_READ), read_data == 8'd0)

	`CRSM_ASSERT_IMP(a_rom_only_on_fetch, clk, arst_n,
		done && (outcome != OUT_ROM_FETCH), rom_address == 23'd0)

	`CRSM_ASSERT_NEVER(a_cfg_always_ready, clk, arst_n, cfg_valid && !cfg_ready)

endmodule

bind cartridge_rom_sram_mapper crsm_checker u_crsm_checker (.*);
